// ===== design/sadct_pkg.sv =====
// Shared types, sizes and the cosine basis table for the shape-adaptive DCT.
// No dependencies; imported by every module of the block.
`default_nettype none
package sadct_pkg;

  localparam int ROWS  = 8;
  localparam int COLS  = 8;
  localparam int CELLS = ROWS * COLS;
  localparam int MAXN  = (ROWS > COLS) ? ROWS : COLS;

  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W  = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int CNT_W  = $clog2(MAXN + 1);
  localparam int TAB_N  = MAXN * MAXN * MAXN;
  localparam int TAB_W  = (TAB_N > 1) ? $clog2(TAB_N) : 1;

  localparam int SMP_W  = 16;
  localparam int COEF_W = 24;
  localparam int BAS_W  = 16;
  localparam int ACC_W  = COEF_W + BAS_W + CNT_W + 1;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    present;
  } sadct_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic                     in_shape;
    logic                     last;
  } sadct_out_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

  typedef logic signed [BAS_W-1:0] basis_tab_t [0:TAB_N-1];

  // unsigned shift-subtract quotient, only used while building the table
  function automatic longint unsigned cdiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sqrt(2/len)*cos(pi*(2n+1)*k/(2len)) in Q2.14, same integer recipe as the
  // golden table: Q30 Taylor series for cos, integer sqrt for the scale.
  function automatic logic signed [BAS_W-1:0] basis_val(input int len, input int k,
                                                        input int n);
    longint unsigned v, res, bitv, scale, d, dm, m, x, x2, term, prod, mag;
    longint          sum;
    logic            neg;
    v    = cdiv(64'd1 << 61, 64'(len));
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) if (bitv > v) bitv = bitv >> 2;
    for (int i = 0; i < 32; i++) begin
      if (bitv != 64'd0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    scale = res;
    d   = 64'(2 * len);
    dm  = 64'(4 * len);
    m   = 64'((2 * n + 1) * k);
    m   = m - cdiv(m, dm) * dm;
    if (m > d) m = 2 * d - m;
    neg = 1'b0;
    if (2 * m > d) begin
      m   = d - m;
      neg = 1'b1;
    end
    x    = cdiv(64'd3373259426 * m, d);
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int i = 1; i <= 10; i++) begin
      term = cdiv((term * x2) >> 30, 64'((2 * i - 1) * (2 * i)));
      if (i[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    prod = longint'(sum) * scale;
    mag  = (prod + (64'd1 << 45)) >> 46;
    return neg ? -BAS_W'(mag) : BAS_W'(mag);
  endfunction

  // entry ((len-1)*MAXN + k)*MAXN + n
  function automatic basis_tab_t build_basis_tab();
    basis_tab_t t;
    for (int l = 1; l <= MAXN; l++)
      for (int k = 0; k < MAXN; k++)
        for (int n = 0; n < MAXN; n++)
          t[((l - 1) * MAXN + k) * MAXN + n] =
            (k < l && n < l) ? basis_val(l, k, n) : '0;
    return t;
  endfunction

  localparam basis_tab_t BASIS = build_basis_tab();

endpackage
`default_nettype wire

// ===== design/sadct_mac.sv =====
// Shared multiply-accumulate unit with Q.14 -> Q.0 rounding and saturation.
// Depends on sadct_pkg.
`default_nettype none
module sadct_mac import sadct_pkg::*; (
  input  wire logic                     clk,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic signed [COEF_W-1:0] op_a,
  input  wire logic signed [BAS_W-1:0]  op_b,
  output logic signed [COEF_W-1:0]      result
);

  localparam int PROD_W = COEF_W + BAS_W;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (COEF_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd1 <<< (COEF_W - 1));

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  shf;

  always_ff @(posedge clk) begin
    if (ctrl.mul) prod_r <= op_a * op_b;
    if (ctrl.clr) acc_r <= '0;
    else if (ctrl.acc) acc_r <= acc_r + ACC_W'(prod_r);
  end

  // floor shift after adding half: ties go toward plus infinity
  always_comb begin
    rnd = acc_r + ACC_W'(1 << 13);
    shf = rnd >>> 14;
    if (shf > SAT_MAX) result = COEF_W'(SAT_MAX);
    else if (shf < SAT_MIN) result = COEF_W'(SAT_MIN);
    else result = COEF_W'(shf);
  end

endmodule
`default_nettype wire

// ===== design/shape_adaptive_dct_forward.sv =====
// Top level of the forward shape-adaptive 2-D DCT: load, column pass, row pass.
// Depends on sadct_pkg and sadct_mac.
//
//  channel  ports                     transfer when
//  input    start, busy, in_item      start && !busy
//  output   out_valid, out_item       out_valid (one cycle, no backpressure)
//
// Loading takes one cycle per sample; busy stays low until the last sample of
// the block. Then the single MAC runs both passes: each line is scanned for
// its held entries, then each coefficient alternates a read and a multiply step
// for every held entry before its sum is written back; in the row pass each
// out-of-shape position is emitted as a zero coefficient.
// Results leave in raster order while busy is high; nothing stalls them.
// Reset (rst_n low, synchronous) clears the shape mask, the load position, the sequencer and out_valid.
`default_nettype none
module shape_adaptive_dct_forward import sadct_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire sadct_in_t  in_item,
  output logic            out_valid,
  output sadct_out_t      out_item
);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_SCAN = 6'b000010,
    S_KCHK = 6'b000100,
    S_RD   = 6'b001000,
    S_MUL  = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SMP_W-1:0]  samp_mem [0:CELLS-1];
  logic signed [COEF_W-1:0] cres_mem [0:CELLS-1];
  logic signed [SMP_W-1:0]  samp_q_r;
  logic signed [COEF_W-1:0] cres_q_r;
  logic signed [BAS_W-1:0]  coef_r;
  logic [CELLS-1:0]         mask_r;
  logic [CELL_W-1:0]        load_idx_r;

  logic                     col_pass_r, col_pass_nxt;
  logic [IDX_W-1:0]         line_r, line_nxt;
  logic [IDX_W-1:0]         scan_r, scan_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         n_r, n_nxt;
  logic [IDX_W-1:0]         plist_r [0:MAXN-1];
  logic [CNT_W-1:0]         colcnt_r [0:COLS-1];

  logic                     scan_hit;
  logic                     scan_end;
  logic                     last_line;
  logic                     emit_zero, emit_coef, wr_cres;
  logic [CELL_W-1:0]        rd_addr, wr_addr;
  logic [TAB_W-1:0]         tab_idx;
  logic signed [COEF_W-1:0] mac_a;
  logic signed [COEF_W-1:0] mac_res;
  mac_ctrl_t                mac_ctrl;

  assign busy = (state_r != S_LOAD);

  // load side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      load_idx_r <= '0;
    end else if (start && !busy) begin
      mask_r[load_idx_r] <= in_item.present;
      load_idx_r <= (load_idx_r == CELL_W'(CELLS - 1)) ? '0 : load_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) samp_mem[load_idx_r] <= in_item.sample;
    samp_q_r <= samp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_cres) cres_mem[wr_addr] <= mac_res;
    cres_q_r <= cres_mem[rd_addr];
  end

  always_comb begin
    if (col_pass_r) scan_hit = mask_r[CELL_W'(int'(scan_r) * COLS + int'(line_r))];
    else scan_hit = (CNT_W'(line_r) < colcnt_r[scan_r]);
    scan_end  = col_pass_r ? (scan_r == IDX_W'(ROWS - 1)) : (scan_r == IDX_W'(COLS - 1));
    last_line = col_pass_r ? (line_r == IDX_W'(COLS - 1)) : (line_r == IDX_W'(ROWS - 1));
    if (col_pass_r) rd_addr = CELL_W'(int'(plist_r[n_r]) * COLS + int'(line_r));
    else rd_addr = CELL_W'(int'(line_r) * COLS + int'(plist_r[n_r]));
    wr_addr = CELL_W'(int'(k_r) * COLS + int'(line_r));
    tab_idx = TAB_W'(((int'(cnt_r) - 1) * MAXN + int'(k_r)) * MAXN + int'(n_r));
    mac_a   = col_pass_r ? COEF_W'(samp_q_r) : cres_q_r;
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    col_pass_nxt = col_pass_r;
    line_nxt     = line_r;
    scan_nxt     = scan_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    mac_ctrl     = '0;
    emit_zero    = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (start && load_idx_r == CELL_W'(CELLS - 1)) begin
          col_pass_nxt = 1'b1;
          line_nxt     = '0;
          scan_nxt     = '0;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) cnt_nxt = cnt_r + 1'b1;
        scan_nxt = scan_r + 1'b1;
        if (scan_end) begin
          k_nxt     = '0;
          state_nxt = S_KCHK;
        end
      end
      S_KCHK: begin
        if (k_r < cnt_r) begin
          n_nxt        = '0;
          mac_ctrl.clr = 1'b1;
          state_nxt    = S_RD;
        end else if (!col_pass_r && k_r < CNT_W'(COLS)) begin
          emit_zero = 1'b1;
          k_nxt     = k_r + 1'b1;
        end else begin
          scan_nxt = '0;
          cnt_nxt  = '0;
          line_nxt = line_r + 1'b1;
          state_nxt = S_SCAN;
          if (last_line) begin
            line_nxt = '0;
            if (col_pass_r) col_pass_nxt = 1'b0;
            else state_nxt = S_LOAD;
          end
        end
      end
      S_RD: begin
        // previous product (if any) folds in while this read is in flight
        mac_ctrl.acc = (n_r != '0);
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.mul = 1'b1;
        if (CNT_W'(n_r) == cnt_r - 1'b1) begin
          state_nxt = S_WB;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_WB: begin
        // final product is added here; result is read the cycle after
        mac_ctrl.acc = 1'b1;
        state_nxt    = S_KCHK;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // the last accumulate lands at the end of S_WB; emit/write in the cycle after
  logic wb_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) wb_pend_r <= 1'b0;
    else wb_pend_r <= (state_r == S_WB);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) coef_r <= BASIS[tab_idx];
    if (state_r == S_SCAN && scan_hit) plist_r[cnt_r[IDX_W-1:0]] <= scan_r;
    if (state_r == S_SCAN && scan_end && col_pass_r)
      colcnt_r[line_r] <= scan_hit ? cnt_r + 1'b1 : cnt_r;
  end

  logic [CNT_W-1:0] k_wb_r;

  always_ff @(posedge clk) begin
    if (state_r == S_WB) k_wb_r <= k_r;
  end

  assign emit_coef = wb_pend_r && !col_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      col_pass_r <= 1'b0;
      line_r     <= '0;
      scan_r     <= '0;
      cnt_r      <= '0;
      k_r        <= '0;
      n_r        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // hold the sequencer while a finished sum is written out
      if (!wb_pend_r) begin
        state_r    <= state_nxt;
        col_pass_r <= col_pass_nxt;
        line_r     <= line_nxt;
        scan_r     <= scan_nxt;
        cnt_r      <= cnt_nxt;
        k_r        <= k_nxt;
        n_r        <= n_nxt;
      end else begin
        k_r <= k_r + 1'b1;
      end
      out_valid <= (emit_zero && !wb_pend_r) || emit_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_coef) begin
      out_item.coefficient <= mac_res;
      out_item.in_shape    <= 1'b1;
      out_item.last        <= (line_r == IDX_W'(ROWS - 1)) && (k_wb_r == CNT_W'(COLS - 1));
    end else begin
      out_item.coefficient <= '0;
      out_item.in_shape    <= 1'b0;
      out_item.last        <= (line_r == IDX_W'(ROWS - 1)) && (k_r == CNT_W'(COLS - 1));
    end
  end

  assign wr_cres = wb_pend_r && col_pass_r;

  sadct_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (mac_a),
    .op_b   (coef_r),
    .result (mac_res)
  );

endmodule
`default_nettype wire
